FILE: hdl/pfan_pkg.sv
// Shared types and constants for the polygon fan triangulator.
`timescale 1ns / 1ps
package pfan_pkg;

    localparam int INDEX_W        = 24;
    localparam int COUNT_W        = 7;
    localparam int MAX_FACE_VERTS = 64;
    localparam int TRI_W          = 6;
    localparam int CFG_ADDR_W     = 2;
    localparam int IN_DATA_W      = 8;
    localparam int OUT_DATA_W     = 3 * INDEX_W;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = 1;
    localparam int QCNT_W         = 2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FLIP_WINDING  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL_INDICES = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_BASE    = 2'd2;

    typedef struct packed {
        logic               flip_winding;
        logic [INDEX_W-1:0] total_indices;
        logic [INDEX_W-1:0] index_base;
    } t_cfg;

    // One classified face request as it travels from front to back
    typedef struct packed {
        logic               err;
        logic [INDEX_W-1:0] pos;
        logic [TRI_W-1:0]   tris;
    } t_cmd;

endpackage

FILE: hdl/pfan_front.sv
// Front end: classifies each face and tracks the running vertex offset.
`timescale 1ns / 1ps
module pfan_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [pfan_pkg::COUNT_W-1:0]  i_count,
    input  logic [pfan_pkg::INDEX_W-1:0]  i_total,
    output pfan_pkg::t_cmd                o_cmd
);
    import pfan_pkg::*;

    logic [INDEX_W-1:0] r_offset, n_offset;
    logic               r_err, n_err;
    logic [INDEX_W:0]   last_pos;
    logic               bad_count;
    logic               out_of_bounds;
    logic               face_err;

    always_comb begin
        // position of the final corner of the last triangle
        last_pos      = {1'b0, r_offset} + (INDEX_W+1)'(i_count) - (INDEX_W+1)'(1);
        bad_count     = (i_count < COUNT_W'(3)) || (i_count > COUNT_W'(MAX_FACE_VERTS));
        out_of_bounds = last_pos >= {1'b0, i_total};
        face_err      = r_err || bad_count || out_of_bounds;

        o_cmd.err  = face_err;
        o_cmd.pos  = r_offset;
        o_cmd.tris = TRI_W'(i_count - COUNT_W'(2));

        n_offset = r_offset;
        n_err    = r_err;
        if (i_accept) begin
            if (face_err) begin
                n_err = 1'b1;
            end else begin
                n_offset = r_offset + INDEX_W'(i_count);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_err    <= 1'b0;
        end else begin
            r_offset <= n_offset;
            r_err    <= n_err;
        end
    end

endmodule

FILE: hdl/pfan_cmd_queue.sv
// Two-entry request queue between the front and back ends.
`timescale 1ns / 1ps
module pfan_cmd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pfan_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output pfan_pkg::t_cmd  o_cmd
);
    import pfan_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push, do_pop;

    always_comb begin
        o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
        o_valid = (r_cnt != '0);
        o_cmd   = r_mem[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && o_valid;
        n_wr    = do_push ? r_wr + QPTR_W'(1) : r_wr;
        n_rd    = do_pop  ? r_rd + QPTR_W'(1) : r_rd;
        n_cnt   = r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("request queue count out of range");

    q_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |=> (r_cnt <= QCNT_W'(1)))
        else $error("request queue grew by more than one");

    q_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + QCNT_W'(1)))
        else $error("request queue lost a push");

endmodule

FILE: hdl/pfan_back.sv
// Back end: expands requests into fan triangles, one per cycle unless stalled.
`timescale 1ns / 1ps
module pfan_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pfan_pkg::t_cfg                   i_cfg,
    input  logic                             i_cmd_valid,
    input  pfan_pkg::t_cmd                   i_cmd,
    output logic                             o_cmd_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [pfan_pkg::OUT_DATA_W-1:0]  o_data,
    output logic                             o_last,
    output logic                             o_err
);
    import pfan_pkg::*;

    logic               r_busy, n_busy;
    logic               r_cerr, n_cerr;
    logic [TRI_W-1:0]   r_left, n_left;
    logic [INDEX_W-1:0] r_pivot, n_pivot;
    logic [INDEX_W-1:0] r_b, n_b;

    logic               r_ovalid, n_ovalid;
    logic [INDEX_W-1:0] r_a, n_a, r_ob, n_ob, r_oc, n_oc;
    logic               r_last, n_last, r_oerr, n_oerr;

    logic               can_load, emit, last_now;
    logic [INDEX_W-1:0] c_pos;

    always_comb begin
        can_load  = !r_ovalid || i_ready;
        emit      = r_busy && can_load;
        last_now  = r_cerr || (r_left == TRI_W'(1));
        o_cmd_pop = i_cmd_valid && (!r_busy || (emit && last_now));
        c_pos     = r_b + INDEX_W'(1);

        n_busy  = r_busy;
        n_cerr  = r_cerr;
        n_left  = r_left;
        n_pivot = r_pivot;
        n_b     = r_b;
        if (emit) begin
            n_left = r_left - TRI_W'(1);
            n_b    = c_pos;
            if (last_now) begin
                n_busy = 1'b0;
            end
        end
        if (o_cmd_pop) begin
            // load next face: pivot and second corner of its first triangle
            n_busy  = 1'b1;
            n_cerr  = i_cmd.err;
            n_left  = i_cmd.tris;
            n_pivot = i_cfg.index_base + i_cmd.pos;
            n_b     = i_cfg.index_base + i_cmd.pos + INDEX_W'(1);
        end

        n_ovalid = r_ovalid && !i_ready;
        n_a      = r_a;
        n_ob     = r_ob;
        n_oc     = r_oc;
        n_last   = r_last;
        n_oerr   = r_oerr;
        if (emit) begin
            n_ovalid = 1'b1;
            n_last   = last_now;
            n_oerr   = r_cerr;
            if (r_cerr) begin
                n_a  = '0;
                n_ob = '0;
                n_oc = '0;
            end else begin
                n_a  = r_pivot;
                n_ob = i_cfg.flip_winding ? c_pos : r_b;
                n_oc = i_cfg.flip_winding ? r_b : c_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cerr  <= n_cerr;
        r_left  <= n_left;
        r_pivot <= n_pivot;
        r_b     <= n_b;
        r_a     <= n_a;
        r_ob    <= n_ob;
        r_oc    <= n_oc;
        r_last  <= n_last;
        r_oerr  <= n_oerr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = {r_oc, r_ob, r_a};
    assign o_last  = r_last;
    assign o_err   = r_oerr;

    b_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oerr) |-> (r_last && r_a == '0 && r_ob == '0 && r_oc == '0))
        else $error("error result must be a single zeroed result");

    b_good_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_cerr) |-> (r_left != '0))
        else $error("active face with no triangles left");

    b_emit_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !$past(r_ovalid)) |-> $past(r_busy))
        else $error("result appeared without an active face");

endmodule

FILE: hdl/polygon_fan_triangulator_unit.sv
// Top level of the polygon fan triangulator: config registers, front, queue, back.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+--------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata[6:0] face_vertex_count
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata a,b,c; tlast; tuser error
//  cfg      | in  | i_cfg_we                     | i_cfg_addr, i_cfg_wdata
//
// A face of n vertices yields n-2 triangles (one per cycle unless the output stalls);
// an error face yields one zeroed result. The single back-end triangle generator sets this.
// The front classifies a face in the cycle it is accepted; a two-entry queue lets
// it run ahead while the output stalls. Synchronous active-low reset clears the
// offset, the sticky error, the queue and the output valid; config resets to zero.
`timescale 1ns / 1ps
module polygon_fan_triangulator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pfan_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [6:0] face_vertex_count
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pfan_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // corner_a, corner_b, corner_c
    output logic                              m_axis_tlast,
    output logic [0:0]                        m_axis_tuser,   // [0] topology_error
    input  logic                              i_cfg_we,
    input  logic [pfan_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [pfan_pkg::INDEX_W-1:0]      i_cfg_wdata
);
    import pfan_pkg::*;

    t_cfg  r_cfg;
    t_cmd  front_cmd;
    t_cmd  q_cmd;
    logic  q_full, q_valid, q_pop;
    logic  in_accept;
    logic  err_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FLIP_WINDING:  r_cfg.flip_winding  <= i_cfg_wdata[0];
                CFG_TOTAL_INDICES: r_cfg.total_indices <= i_cfg_wdata;
                CFG_INDEX_BASE:    r_cfg.index_base    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && !q_full;

    pfan_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(in_accept),
        .i_count (s_axis_tdata[COUNT_W-1:0]),
        .i_total (r_cfg.total_indices),
        .o_cmd   (front_cmd)
    );

    pfan_cmd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (in_accept),
        .i_cmd  (front_cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_cmd  (q_cmd)
    );

    pfan_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_valid(q_valid),
        .i_cmd      (q_cmd),
        .o_cmd_pop  (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_last     (m_axis_tlast),
        .o_err      (err_bit)
    );

    assign m_axis_tuser = err_bit;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the polygon fan triangulator: stream stimulus, predictor, checker.
`timescale 1ns / 1ps
module tb_top;
    import pfan_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;

    typedef struct {
        logic [INDEX_W-1:0] a;
        logic [INDEX_W-1:0] b;
        logic [INDEX_W-1:0] c;
        logic               last;
        logic               err;
    } t_tri;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tlast;
    logic [0:0]              m_axis_tuser;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr = '0;
    logic [INDEX_W-1:0]      i_cfg_wdata = '0;

    // predictor state and register copies
    logic                    cfg_flip = 1'b0;
    logic [INDEX_W-1:0]      cfg_total = '0;
    logic [INDEX_W-1:0]      cfg_base = '0;
    logic [INDEX_W-1:0]      vert_off = '0;
    logic                    err_sticky = 1'b0;

    t_tri                    pending_tris[$];
    t_tri                    got_exp;
    int                      mismatches = 0;
    int                      cycle_count = 0;
    bit                      quiet_mode = 1'b0;
    int                      hold_req = 0;
    int                      hold_seen = 0;
    int                      hold_left = 0;
    int                      stall_left = 0;
    logic                    ready_nx;

    polygon_fan_triangulator_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: long hold on request, otherwise random stall bursts unless quiet.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready_nx = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            ready_nx = 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            ready_nx = 1'b0;
        end else begin
            ready_nx = 1'b1;
        end
        m_axis_tready <= ready_nx;
    end

    task automatic check_field(input string name, input logic [INDEX_W-1:0] exp_v,
                               input logic [INDEX_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_tris.size() == 0) begin
                $display("%0t: unexpected triangle, expected none actual %h last %b err %b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                mismatches++;
            end else begin
                got_exp = pending_tris.pop_front();
                check_field("corner_a", got_exp.a, m_axis_tdata[INDEX_W-1:0]);
                check_field("corner_b", got_exp.b, m_axis_tdata[2*INDEX_W-1:INDEX_W]);
                check_field("corner_c", got_exp.c, m_axis_tdata[3*INDEX_W-1:2*INDEX_W]);
                check_field("last_of_face", INDEX_W'(got_exp.last), INDEX_W'(m_axis_tlast));
                check_field("topology_error", INDEX_W'(got_exp.err),
                            INDEX_W'(m_axis_tuser[0]));
            end
        end
    end

    // Expected triangles of one face; updates offset and sticky error.
    task automatic fan_triangles(input logic [COUNT_W-1:0] n);
        t_tri t;
        int   j;
        if (err_sticky || n < 3 || n > MAX_FACE_VERTS ||
            int'(vert_off) + int'(n) - 1 >= int'(cfg_total)) begin
            t.a = '0;
            t.b = '0;
            t.c = '0;
            t.last = 1'b1;
            t.err = 1'b1;
            pending_tris.insert(pending_tris.size(), t);
            err_sticky = 1'b1;
        end else begin
            for (j = 0; j < int'(n) - 2; j++) begin
                t.a = cfg_base + vert_off;
                t.b = cfg_base + vert_off + INDEX_W'(j + 1);
                t.c = cfg_base + vert_off + INDEX_W'(j + 2);
                if (cfg_flip) begin
                    t.b = cfg_base + vert_off + INDEX_W'(j + 2);
                    t.c = cfg_base + vert_off + INDEX_W'(j + 1);
                end
                t.last = (j == int'(n) - 3);
                t.err = 1'b0;
                pending_tris.insert(pending_tris.size(), t);
            end
            vert_off = vert_off + INDEX_W'(n);
        end
    endtask

    // Called at a rising edge; returns at the edge that accepts the request.
    task automatic send_face(input logic [COUNT_W-1:0] n);
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_W-COUNT_W){1'b0}}, n};
        do @(posedge i_clk); while (!s_axis_tready);
        fan_triangles(n);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_tris.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [INDEX_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            CFG_FLIP_WINDING:  cfg_flip = data[0];
            CFG_TOTAL_INDICES: cfg_total = data;
            CFG_INDEX_BASE:    cfg_base = data;
            default: ;
        endcase
    endtask

    // Mostly small faces, a few mid-size, the odd maximum one.
    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return COUNT_W'($urandom_range(3, 8));
        else if (r < 95)
            return COUNT_W'($urandom_range(9, MAX_FACE_VERTS - 1));
        return COUNT_W'(MAX_FACE_VERTS);
    endfunction

    task automatic test_face_extremes();
        drain();
        write_reg(CFG_FLIP_WINDING, 24'd0);
        write_reg(CFG_TOTAL_INDICES, 24'hFFFFFF);
        write_reg(CFG_INDEX_BASE, 24'd0);
        send_face(7'd3);
        send_face(7'd4);
        send_face(COUNT_W'(MAX_FACE_VERTS));
        send_face(COUNT_W'(MAX_FACE_VERTS - 1));
        send_face(7'd5);
        send_face(7'd3);
    endtask

    task automatic test_winding_and_wrap();
        drain();
        write_reg(CFG_FLIP_WINDING, 24'd1);
        // put the pivot just below the top so corners wrap inside the face
        write_reg(CFG_INDEX_BASE, 24'hFFFFFF - vert_off - 24'd1);
        send_face(7'd6);
        send_face(COUNT_W'(MAX_FACE_VERTS));
        send_face(7'd3);
        drain();
        write_reg(CFG_FLIP_WINDING, 24'd0);
        send_face(7'd4);
    endtask

    task automatic test_random_faces(input int count, input logic flip,
                                     input logic [INDEX_W-1:0] base);
        drain();
        write_reg(CFG_FLIP_WINDING, {23'd0, flip});
        write_reg(CFG_INDEX_BASE, base);
        repeat (count) send_face(pick_count());
    endtask

    task automatic test_backpressure();
        drain();
        write_reg(CFG_FLIP_WINDING, 24'($urandom_range(0, 1)));
        write_reg(CFG_INDEX_BASE, 24'($urandom_range(0, 24'hFFFFFF)));
        hold_req <= hold_req + 1;
        repeat (40) send_face(pick_count());
    endtask

    task automatic test_steady_stream();
        quiet_mode = 1'b1;
        repeat (60) send_face(pick_count());
    endtask

    task automatic test_bound_and_sticky_error();
        drain();
        write_reg(CFG_TOTAL_INDICES, vert_off + 24'd5);
        send_face(7'd5);            // last corner lands on the final legal position
        send_face(7'd3);            // one past the bound: first error
        send_face(7'd0);
        send_face(7'd1);
        send_face(7'd2);
        send_face(COUNT_W'(MAX_FACE_VERTS + 1));
        send_face(7'd127);
        send_face(COUNT_W'(MAX_FACE_VERTS));
        send_face(7'd3);
        drain();
        write_reg(CFG_TOTAL_INDICES, 24'd0);
        repeat (20) send_face(COUNT_W'($urandom_range(0, 127)));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_face_extremes();
        test_winding_and_wrap();
        test_random_faces(150, 1'b0, 24'd0);
        test_random_faces(120, 1'b1, 24'hFFFF00);
        test_backpressure();
        test_steady_stream();
        test_bound_and_sticky_error();
        drain();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
